[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL.
// Every check is sampled on the rising edge of i_clk and is held off while
// the synchronous reset i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds on every clock edge.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checks that a condition is never true.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

[src/scms_pkg.sv]
// ---------------------------------------------------------------------------
// scms_pkg
// Widths and constants of the sigma-clipped mean and sigma block.
// ---------------------------------------------------------------------------
package scms_pkg;

    // Default parameter values.
    localparam int PAD_MAX_DEF     = 4096;
    localparam int CLIP_PASSES_DEF = 2;

    // Field widths.
    localparam int VAL_W       = 24;
    localparam int WGT_W       = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_W       = 32;
    localparam int KEPT_W      = 13;
    localparam int OUT_TDATA_W = 80;

    // Internal datapath widths.
    localparam int MEAN_W = 40;   // Q.8 mean
    localparam int SIG_W  = 33;   // Q.8 sigma
    localparam int ACC_W  = 128;  // shared unit and second moment
    localparam int MPL_W  = 64;   // multiplier operand, first moment
    localparam int WT_W   = 32;   // weight total

    // Unit constants.
    localparam int DIV_STEPS  = 128;
    localparam int SQRT_START = 62;

    // Result constants.
    localparam int ONE_Q8     = 256;
    localparam int KEPT_EMPTY = 10;

endpackage

[src/sigma_clipped_mean_sigma_top.sv]
// ---------------------------------------------------------------------------
// sigma_clipped_mean_sigma_top
// Weighted mean and RMS of one image pad with iterative 2-sigma clipping.
// ---------------------------------------------------------------------------
// Pixels arrive one beat at a time and are stored in an on-chip pad memory of
// PAD_MAX entries; pixels beyond PAD_MAX are dropped but a last mark still
// ends the pad. Multiplies, divides and the square root run through one shared
// 128-bit add/subtract unit under a sequencer: multiplies are shift-and-add (one
// multiplier bit a cycle, ending early when the remaining bits are zero) and
// divides are restoring. Each loaded pixel's magnitude is multiplied by its
// weight, then by the magnitude again. After the last pixel, each moment
// evaluation divides, rounds, squares the shift, divides again and takes the
// square root, and each of the CLIP_PASSES passes reads the stored pixels
// through the single memory read port and multiplies out each kept pixel.
// The input is not ready while a pad is being reduced; a finished result
// waits in the output register while the next pad loads.
// ---------------------------------------------------------------------------
module sigma_clipped_mean_sigma_top
    import scms_pkg::*;
#(
    parameter int PAD_MAX     = PAD_MAX_DEF,
    parameter int CLIP_PASSES = CLIP_PASSES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write channel: use_weight.
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_data,
    // Pixel input stream.
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // pixel_value[23:0], pixel_weight[39:24]
    input  logic                   i_s_axis_tlast,   // last_pixel
    // Result stream.
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // clipped_mean[31:0],
                                                      // clipped_sigma[63:32],
                                                      // kept_count[76:64], zero fill
    output logic [0:0]             o_m_axis_tuser    // empty_pad[0]
);

    localparam int IW       = (PAD_MAX > 1) ? $clog2(PAD_MAX) : 1;
    localparam int CW       = $clog2(PAD_MAX + 1);
    localparam int PW       = $clog2(CLIP_PASSES + 1);
    localparam int STEP_W   = $clog2(DIV_STEPS);

    typedef enum logic [4:0] {
        S_IDLE, S_LD1, S_LD2, S_INIT, S_DIV1, S_RND, S_QSQ, S_DIV2, S_VAR,
        S_SQRT, S_PSTART, S_PRD, S_PEVAL, S_PM1, S_PM2, S_PEND, S_DONE
    } t_state;

    t_state r_state;

    // Pad memory.
    logic signed [VAL_W-1:0] r_mem_v [PAD_MAX];
    logic        [WGT_W-1:0] r_mem_w [PAD_MAX];
    logic signed [VAL_W-1:0] r_rd_v;
    logic        [WGT_W-1:0] r_rd_w;

    // Pad accumulators and configuration.
    logic                    r_use_weight;
    logic [CW-1:0]           r_cnt;
    logic signed [MPL_W-1:0] r_wsum;
    logic [ACC_W-1:0]        r_sq;
    logic [WT_W-1:0]         r_wt;
    logic                    r_last;
    logic                    r_vneg;
    logic [MEAN_W-1:0]       r_mag;

    // Shared unit operand registers.
    logic [ACC_W-1:0]        r_acc;
    logic [ACC_W-1:0]        r_mcand;
    logic [MPL_W-1:0]        r_mplier;
    logic [STEP_W-1:0]       r_step;

    // Clipping state.
    logic signed [MEAN_W-1:0] r_mean;
    logic [SIG_W-1:0]         r_sig;
    logic                     r_neg;
    logic [MPL_W-1:0]         r_s2;
    logic [MPL_W-1:0]         r_pos;
    logic [MPL_W-1:0]         r_negs;
    logic [CW-1:0]            r_n;
    logic [CW-1:0]            r_npix;
    logic                     r_empty;
    logic [IW-1:0]            r_idx;
    logic [PW-1:0]            r_pass;

    // Output register.
    logic                     r_ovalid;
    logic [OUT_W-1:0]         r_omean;
    logic [OUT_W-1:0]         r_osig;
    logic [KEPT_W-1:0]        r_okept;
    logic                     r_oempty;

    // Combinational helpers.
    logic [ACC_W-1:0]         u_a;
    logic [ACC_W-1:0]         u_b;
    logic                     u_sub;
    logic [ACC_W:0]           u_res;
    logic                     mul_done;
    logic [WT_W:0]            div_rs;
    logic                     in_accept;
    logic signed [VAL_W-1:0]  in_v;
    logic [VAL_W-1:0]         in_mag;
    logic [WGT_W-1:0]         in_w;
    logic [MPL_W-1:0]         wsum_mag;
    logic signed [MEAN_W-1:0] p_val;
    logic signed [MEAN_W-1:0] p_d;
    logic [MEAN_W-1:0]        p_mag;
    logic                     p_keep;
    logic                     p_last;
    logic [MPL_W-1:0]         q_rnd;
    logic [MPL_W-1:0]         q_shift;
    logic                     rnd_up;
    logic [MPL_W-1:0]         q2_sat;
    logic [MPL_W-1:0]         var_q16;
    logic [31:0]              npix_ext;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    // Input beat decode.
    assign in_v   = $signed(i_s_axis_tdata[VAL_W-1:0]);
    assign in_mag = in_v[VAL_W-1] ? VAL_W'(-in_v) : VAL_W'(in_v);
    assign in_w   = r_use_weight ? i_s_axis_tdata[VAL_W +: WGT_W] : WGT_W'(ONE_Q8);

    // Shared add/subtract unit; a subtract's carry out means a >= b.
    assign div_rs = {r_acc[WT_W-1:0], r_mcand[ACC_W-1]};
    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
        case (r_state)
            S_LD1, S_LD2, S_PM1, S_PM2, S_QSQ: begin
                u_a = r_acc;
                u_b = r_mcand;
            end
            S_DIV1, S_DIV2: begin
                u_a   = ACC_W'(div_rs);
                u_b   = ACC_W'(r_wt);
                u_sub = 1'b1;
            end
            S_SQRT: begin
                u_a   = ACC_W'(r_acc[MPL_W-1:0]);
                u_b   = ACC_W'(r_mcand[MPL_W-1:0] | r_mplier);
                u_sub = 1'b1;
            end
            default: begin
                u_sub = 1'b0;
            end
        endcase
        u_res = {1'b0, u_a} + {1'b0, (u_sub ? ~u_b : u_b)} + (ACC_W + 1)'(u_sub);
    end

    assign mul_done = (r_mplier == '0);

    // Magnitude of the first moment for the initial estimate, in Q.8.
    assign wsum_mag = (r_wsum[MPL_W-1] ? MPL_W'(-r_wsum) : MPL_W'(r_wsum)) << 8;

    // Deviation of the stored pixel from the current mean and the 2-sigma cut.
    assign p_val  = {{(MEAN_W - VAL_W){r_rd_v[VAL_W-1]}}, r_rd_v};
    assign p_d    = (p_val <<< 8) - r_mean;
    assign p_mag  = p_d[MEAN_W-1] ? MEAN_W'(-p_d) : MEAN_W'(p_d);
    assign p_keep = (r_rd_w != '0) && (p_mag <= MEAN_W'({r_sig, 1'b0}));
    assign p_last = ((CW'(r_idx) + CW'(1)) == r_cnt);

    // Rounded mean shift, ties away from zero.
    assign rnd_up  = {r_acc[WT_W-1:0], 1'b0} >= {1'b0, r_wt};
    assign q_rnd   = r_mcand[MPL_W-1:0] + MPL_W'(rnd_up);
    assign q_shift = r_neg ? (~q_rnd + MPL_W'(1)) : q_rnd;

    // Variance from the saturated second moment quotient.
    assign q2_sat  = (r_mcand[ACC_W-1:MPL_W] != '0) ? '1 : r_mcand[MPL_W-1:0];
    assign var_q16 = (q2_sat > r_s2) ? (q2_sat - r_s2) : '0;

    assign npix_ext = 32'(r_npix);

    // Pad memory write on each stored pixel and registered read at r_idx.
    always_ff @(posedge i_clk) begin
        if (in_accept && (r_cnt < CW'(PAD_MAX))) begin
            r_mem_v[r_cnt[IW-1:0]] <= in_v;
            r_mem_w[r_cnt[IW-1:0]] <= in_w;
        end
        r_rd_v <= r_mem_v[r_idx];
        r_rd_w <= r_mem_w[r_idx];
    end

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_use_weight <= 1'b0;
            r_cnt        <= '0;
            r_wsum       <= '0;
            r_sq         <= '0;
            r_wt         <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_use_weight <= i_cfg_data;
            end
            // A taken result empties the output register unless a new one loads.
            if (r_ovalid && i_m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                // Accept a pixel and start its first moment product.
                S_IDLE: begin
                    if (in_accept) begin
                        r_last <= i_s_axis_tlast;
                        if (r_cnt < CW'(PAD_MAX)) begin
                            r_cnt    <= r_cnt + CW'(1);
                            r_wt     <= r_wt + WT_W'(in_w);
                            r_vneg   <= in_v[VAL_W-1];
                            r_mag    <= MEAN_W'(in_mag);
                            r_acc    <= '0;
                            r_mcand  <= ACC_W'(in_mag);
                            r_mplier <= MPL_W'(in_w);
                            r_state  <= S_LD1;
                        end else if (i_s_axis_tlast) begin
                            r_state <= S_INIT;
                        end
                    end
                end

                // Weight times magnitude, then times magnitude again.
                S_LD1: begin
                    if (mul_done) begin
                        r_wsum   <= r_vneg ? (r_wsum - $signed(r_acc[MPL_W-1:0]))
                                           : (r_wsum + $signed(r_acc[MPL_W-1:0]));
                        r_mcand  <= r_acc;
                        r_mplier <= MPL_W'(r_mag);
                        r_acc    <= '0;
                        r_state  <= S_LD2;
                    end else begin
                        if (r_mplier[0]) r_acc <= u_res[ACC_W-1:0];
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end

                S_LD2: begin
                    if (mul_done) begin
                        r_sq    <= r_sq + r_acc;
                        r_state <= r_last ? S_INIT : S_IDLE;
                    end else begin
                        if (r_mplier[0]) r_acc <= u_res[ACC_W-1:0];
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end

                // Initial estimate, or the defaults for a pad without weight.
                S_INIT: begin
                    r_mean <= '0;
                    r_pass <= '0;
                    if (r_wt == '0) begin
                        r_empty <= 1'b1;
                        r_sig   <= SIG_W'(ONE_Q8);
                        r_state <= S_DONE;
                    end else begin
                        r_empty <= 1'b0;
                        r_neg   <= r_wsum[MPL_W-1];
                        r_sq    <= r_sq << 16;
                        r_mcand <= ACC_W'(wsum_mag);
                        r_acc   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV1;
                    end
                end

                // First or second moment over weight: restoring divide.
                S_DIV1, S_DIV2: begin
                    if (u_res[ACC_W]) begin
                        r_acc   <= ACC_W'(u_res[WT_W-1:0]);
                        r_mcand <= {r_mcand[ACC_W-2:0], 1'b1};
                    end else begin
                        r_acc   <= ACC_W'(div_rs[WT_W-1:0]);
                        r_mcand <= {r_mcand[ACC_W-2:0], 1'b0};
                    end
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= (r_state == S_DIV1) ? S_RND : S_VAR;
                    end
                end

                // Round the shift, move the mean, then square the shift.
                S_RND: begin
                    r_mean   <= r_mean + $signed(q_shift[MEAN_W-1:0]);
                    r_mcand  <= ACC_W'(q_rnd);
                    r_mplier <= q_rnd;
                    r_acc    <= '0;
                    r_state  <= S_QSQ;
                end

                S_QSQ: begin
                    if (mul_done) begin
                        r_s2    <= r_acc[MPL_W-1:0];
                        r_mcand <= r_sq;
                        r_acc   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV2;
                    end else begin
                        if (r_mplier[0]) r_acc <= u_res[ACC_W-1:0];
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end

                // Variance, then its integer square root.
                S_VAR: begin
                    r_acc    <= ACC_W'(var_q16);
                    r_mcand  <= '0;
                    r_mplier <= MPL_W'(1) << SQRT_START;
                    r_state  <= S_SQRT;
                end

                S_SQRT: begin
                    if (r_mplier == '0) begin
                        r_sig   <= r_mcand[SIG_W-1:0];
                        r_state <= S_PSTART;
                    end else begin
                        if (u_res[ACC_W]) begin
                            r_acc   <= ACC_W'(u_res[MPL_W-1:0]);
                            r_mcand <= ACC_W'((r_mcand[MPL_W-1:0] >> 1) | r_mplier);
                        end else begin
                            r_mcand <= ACC_W'(r_mcand[MPL_W-1:0] >> 1);
                        end
                        r_mplier <= r_mplier >> 2;
                    end
                end

                // Start a clipping pass over the stored pad, or finish after CLIP_PASSES passes.
                S_PSTART: begin
                    if (r_pass == PW'(CLIP_PASSES)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pos   <= '0;
                        r_negs  <= '0;
                        r_sq    <= '0;
                        r_wt    <= '0;
                        r_n     <= '0;
                        r_idx   <= '0;
                        r_state <= S_PRD;
                    end
                end

                S_PRD: begin
                    r_state <= S_PEVAL;
                end

                // Keep or reject one stored pixel.
                S_PEVAL: begin
                    if (p_keep) begin
                        r_n      <= r_n + CW'(1);
                        r_wt     <= r_wt + WT_W'(r_rd_w);
                        r_vneg   <= p_d[MEAN_W-1];
                        r_mag    <= p_mag;
                        r_acc    <= '0;
                        r_mcand  <= ACC_W'(p_mag);
                        r_mplier <= MPL_W'(r_rd_w);
                        r_state  <= S_PM1;
                    end else if (p_last) begin
                        r_state <= S_PEND;
                    end else begin
                        r_idx   <= r_idx + IW'(1);
                        r_state <= S_PRD;
                    end
                end

                S_PM1: begin
                    if (mul_done) begin
                        if (r_vneg) r_negs <= r_negs + r_acc[MPL_W-1:0];
                        else        r_pos  <= r_pos + r_acc[MPL_W-1:0];
                        r_mcand  <= r_acc;
                        r_mplier <= MPL_W'(r_mag);
                        r_acc    <= '0;
                        r_state  <= S_PM2;
                    end else begin
                        if (r_mplier[0]) r_acc <= u_res[ACC_W-1:0];
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end

                S_PM2: begin
                    if (mul_done) begin
                        r_sq <= r_sq + r_acc;
                        if (p_last) begin
                            r_state <= S_PEND;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_PRD;
                        end
                    end else begin
                        if (r_mplier[0]) r_acc <= u_res[ACC_W-1:0];
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end

                // End of a pass: stop on no weight, else refine the estimate.
                S_PEND: begin
                    r_npix <= r_n;
                    if (r_wt == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_pass  <= r_pass + PW'(1);
                        r_neg   <= (r_pos < r_negs);
                        r_mcand <= ACC_W'((r_pos >= r_negs) ? (r_pos - r_negs)
                                                            : (r_negs - r_pos));
                        r_acc   <= '0;
                        r_step  <= '0;
                        r_state <= S_DIV1;
                    end
                end

                // Hand the result to the output register and clear the pad.
                S_DONE: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_omean  <= OUT_W'(r_mean[OUT_W-1:0]);
                        r_osig   <= r_sig[SIG_W-1] ? '1 : r_sig[OUT_W-1:0];
                        r_okept  <= r_empty ? KEPT_W'(KEPT_EMPTY) : npix_ext[KEPT_W-1:0];
                        r_oempty <= r_empty;
                        r_cnt    <= '0;
                        r_wsum   <= '0;
                        r_sq     <= '0;
                        r_wt     <= '0;
                        r_state  <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - 2 * OUT_W - KEPT_W){1'b0}},
                              r_okept, r_osig, r_omean};
    assign o_m_axis_tuser  = r_oempty;

    // Checks.
`include "assert_macros.svh"

    `ASSERT_CLK(a_out_drops, (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_DONE)) |=> !o_m_axis_tvalid, "result beat repeated after it was taken")
    `ASSERT_CLK(a_empty_defaults, (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> ((o_m_axis_tdata[76:64] == KEPT_W'(KEPT_EMPTY)) && (o_m_axis_tdata[63:32] == OUT_W'(ONE_Q8))), "empty pad result without defaults")
    `ASSERT_NEVER(a_cnt_bound, r_cnt > CW'(PAD_MAX), "pixel count beyond pad storage")

endmodule

[bench/tb_sigma_clipped_mean_sigma_top.sv]
// ---------------------------------------------------------------------------
// tb_sigma_clipped_mean_sigma_top
// Self-checking bench for the sigma-clipped mean and sigma block.
// ---------------------------------------------------------------------------
// Pads of pixels are streamed in, and every accepted pixel is mirrored into
// a bit-accurate pad model that predicts the clipped mean, sigma, kept count
// and empty flag. Each result beat is compared field by field with the
// oldest predicted result. Directed pads cover the field extremes and empty
// pads. Random pads with clustered values and outliers
// follow, with random idle gaps on both streams and long output stalls.
// ---------------------------------------------------------------------------
module tb_sigma_clipped_mean_sigma_top;
    import scms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0]       mean;
        logic [31:0]       sigma;
        logic [KEPT_W-1:0] kept;
        logic              empty;
    } pad_result_t;

    localparam int PAD_DEPTH   = PAD_MAX_DEF;
    localparam int CLIP_ROUNDS = CLIP_PASSES_DEF;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic                   i_cfg_data;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;   // pixel_value[23:0], pixel_weight[39:24]
    logic                   i_s_axis_tlast;   // last_pixel
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;   // clipped_mean[31:0], clipped_sigma[63:32],
                                              // kept_count[76:64]
    logic [0:0]             o_m_axis_tuser;   // empty_pad[0]

    sigma_clipped_mean_sigma_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // Pad model state.
    int              pad_val [PAD_DEPTH];
    logic [15:0]     pad_wgt [PAD_DEPTH];
    int              pad_len;
    longint          sum_wv;
    logic [127:0]    sum_wvv;
    logic [63:0]     sum_w;
    bit              weight_mode;

    pad_result_t     expected_results[$];
    int              error_count;
    bit              src_idle_en;
    bit              sink_idle_en;
    int              hold_seq;
    int              hold_seen;
    int              hold_left;
    int              sink_gap;

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Rounded mean shift and clamped variance from the two moments.
    task automatic mean_shift_and_variance(input logic [63:0] mag, input bit neg,
                                           input logic [127:0] sq, input logic [63:0] w,
                                           output longint shift,
                                           output logic [63:0] variance);
        logic [63:0]  q;
        logic [63:0]  r;
        logic [63:0]  s2;
        logic [63:0]  q2;
        logic [127:0] qw;
        q = mag / w;
        r = mag % w;
        if (r >= w - r) q = q + 1;
        shift = neg ? -longint'(q) : longint'(q);
        s2 = q * q;
        qw = sq / {64'd0, w};
        q2 = (qw[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : qw[63:0];
        variance = (q2 > s2) ? q2 - s2 : 64'd0;
    endtask

    // Mirrors one accepted pixel into the pad model.
    task automatic predict_pixel(input logic [23:0] value, input logic [15:0] weight,
                                 input bit last);
        int          v;
        logic [15:0] w;
        logic [63:0] mag;
        longint      mean8;
        logic [63:0] sig8;
        logic [63:0] npix;
        bit          empty;
        bit          neg;
        logic [63:0] m;
        logic [63:0] variance;
        logic [63:0] pos;
        logic [63:0] negs;
        logic [63:0] wc;
        logic [63:0] cut;
        logic [63:0] mm;
        logic [127:0] sq;
        longint      d;
        longint      shift;
        pad_result_t res;
        v = int'($signed(value));
        w = weight_mode ? weight : 16'(ONE_Q8);
        if (pad_len < PAD_DEPTH) begin
            mag = (v < 0) ? 64'(-v) : 64'(v);
            pad_val[pad_len] = v;
            pad_wgt[pad_len] = w;
            sum_wv = sum_wv + longint'(w) * longint'(v);
            mm = mag * mag * 64'(w);
            sum_wvv = sum_wvv + {64'd0, mm};
            sum_w = sum_w + 64'(w);
            pad_len++;
        end
        if (!last) return;

        mean8 = 0;
        sig8 = 64'(ONE_Q8);
        npix = 64'(KEPT_EMPTY);
        empty = 1'b1;
        if (sum_w != 0) begin
            empty = 1'b0;
            neg = sum_wv < 0;
            m = neg ? 64'(-sum_wv) : 64'(sum_wv);
            m = m * 64'd256;
            mean_shift_and_variance(m, neg, sum_wvv << 16, sum_w, mean8, variance);
            sig8 = isqrt(variance);
            for (int p = 0; p < CLIP_ROUNDS; p++) begin
                pos = 0;
                negs = 0;
                wc = 0;
                npix = 0;
                sq = 0;
                cut = 64'd2 * sig8;
                for (int i = 0; i < pad_len; i++) begin
                    if (pad_wgt[i] == 0) continue;
                    d = longint'(pad_val[i]) * 256 - mean8;
                    mag = (d < 0) ? 64'(-d) : 64'(d);
                    if (mag > cut) continue;
                    if (d < 0) negs = negs + 64'(pad_wgt[i]) * mag;
                    else pos = pos + 64'(pad_wgt[i]) * mag;
                    mm = mag * mag;
                    sq = sq + {64'd0, mm} * {112'd0, pad_wgt[i]};
                    wc = wc + 64'(pad_wgt[i]);
                    npix = npix + 1;
                end
                if (wc == 0) break;
                if (pos >= negs) mean_shift_and_variance(pos - negs, 1'b0, sq, wc, shift, variance);
                else mean_shift_and_variance(negs - pos, 1'b1, sq, wc, shift, variance);
                mean8 = mean8 + shift;
                sig8 = isqrt(variance);
            end
        end
        res.mean = 32'(mean8);
        res.sigma = (sig8 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sig8[31:0];
        res.kept = npix[KEPT_W-1:0];
        res.empty = empty;
        expected_results.push_back(res);
        pad_len = 0;
        sum_wv = 0;
        sum_wvv = 0;
        sum_w = 0;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%08h, expected 0x%08h", $realtime, what,
                 got, want);
        error_count++;
    endtask

    // Result checker: each accepted result beat is checked against one predicted result.
    always @(posedge i_clk) begin
        pad_result_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result beat", o_m_axis_tdata[31:0], 32'd0);
            end else begin
                want = expected_results.pop_front();
                if (o_m_axis_tdata[31:0] !== want.mean)
                    report_mismatch("clipped_mean", o_m_axis_tdata[31:0], want.mean);
                if (o_m_axis_tdata[63:32] !== want.sigma)
                    report_mismatch("clipped_sigma", o_m_axis_tdata[63:32], want.sigma);
                if (o_m_axis_tdata[76:64] !== want.kept)
                    report_mismatch("kept_count", 32'(o_m_axis_tdata[76:64]), 32'(want.kept));
                if (o_m_axis_tuser[0] !== want.empty)
                    report_mismatch("empty_pad", 32'(o_m_axis_tuser[0]), 32'(want.empty));
            end
        end
    end

    // Result sink: random idle gaps plus long holds on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = 800;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (sink_idle_en && $urandom_range(0, 3) == 0) sink_gap = rand_gap();
        end
    end

    // Sends one pixel beat and waits for its acceptance.
    task automatic send_pixel(input logic [23:0] value, input logic [15:0] weight,
                              input bit last);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {weight, value};
        i_s_axis_tlast <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_pixel(value, weight, last);
        gap = src_idle_en ? rand_gap() : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits until every predicted result has arrived and the block is quiet.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic write_use_weight(input bit mode);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        weight_mode = mode;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Pixel value drawn around a pad center, with occasional outliers.
    function automatic logic [23:0] pick_value(input int center, input int spread);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 24'($urandom);
        if (r < 13) return (r == 10) ? 24'h7F_FFFF : 24'h80_0000;
        return 24'(center + $signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic logic [15:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 16'h0000;
        if (r < 16) return 16'hFFFF;
        if (r < 60) return 16'($urandom_range(1, 1023));
        return 16'($urandom);
    endfunction

    task automatic send_random_pad(input int len);
        int center;
        int spread;
        bit all_zero;
        all_zero = ($urandom_range(0, 19) == 0);
        center = ($urandom_range(0, 3) == 0) ? int'($signed(24'($urandom)))
                                             : $signed($urandom_range(0, 2000)) - 1000;
        spread = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(1, 5000);
        for (int i = 0; i < len; i++)
            send_pixel(pick_value(center, spread), all_zero ? 16'h0000 : pick_weight(),
                       i == len - 1);
    endtask

    // Field extremes, single pixels, empty pads and clipping corners.
    task automatic test_directed();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        send_pixel(24'h7F_FFFF, 16'hFFFF, 1'b1);
        send_pixel(24'h80_0000, 16'h0000, 1'b1);
        send_pixel(24'h80_0000, 16'h0001, 1'b0);
        send_pixel(24'h7F_FFFF, 16'h0001, 1'b1);
        write_use_weight(1'b1);
        send_pixel(24'h00_0005, 16'h0000, 1'b0);
        send_pixel(24'hFF_FFFB, 16'h0000, 1'b1);
        send_pixel(24'h80_0000, 16'hFFFF, 1'b0);
        send_pixel(24'h7F_FFFF, 16'hFFFF, 1'b1);
        send_pixel(24'h00_0000, 16'h0001, 1'b0);
        send_pixel(24'h00_0001, 16'hFFFF, 1'b0);
        send_pixel(24'h00_0000, 16'h0000, 1'b1);
        for (int i = 0; i < 7; i++)
            send_pixel(24'(i * 3 - 9), 16'h0100, 1'b0);
        send_pixel(24'h40_0000, 16'h8000, 1'b1);
        send_pixel(24'h00_0010, 16'h0001, 1'b0);
        send_pixel(24'hFF_FFF0, 16'h0001, 1'b0);
        send_pixel(24'h12_3456, 16'h0000, 1'b1);
        write_use_weight(1'b0);
    endtask

    // Long output stall while short pads keep coming back to back.
    task automatic test_output_stall();
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        hold_seq++;
        for (int p = 0; p < 4; p++) send_random_pad(3);
        wait_drained();
    endtask

    // Random pads in both weight modes with idling on both streams.
    task automatic test_random(input int pixels);
        int sent;
        int len;
        sent = 0;
        while (sent < pixels) begin
            if ($urandom_range(0, 59) == 0) write_use_weight(1'($urandom_range(0, 1)));
            src_idle_en = ($urandom_range(0, 4) != 0);
            sink_idle_en = ($urandom_range(0, 4) != 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            send_random_pad(len);
            sent += len;
            if ($urandom_range(0, 99) == 0) test_output_stall();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tlast = 1'b0;
        pad_len = 0;
        sum_wv = 0;
        sum_wvv = 0;
        sum_w = 0;
        weight_mode = 1'b0;
        error_count = 0;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        hold_seq = 0;
        hold_seen = 0;
        hold_left = 0;
        sink_gap = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_output_stall();
        write_use_weight(1'b1);
        test_random(850);
        write_use_weight(1'b0);
        test_random(450);
        write_use_weight(1'b1);
        test_output_stall();
        test_random(400);

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #60_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/scms_pkg.sv
src/sigma_clipped_mean_sigma_top.sv
bench/tb_sigma_clipped_mean_sigma_top.sv
